[design/cmfs_pkg.sv]
package cmfs_pkg;

	// Component and coordinate formats
	localparam int COMPONENT_BITS = 16;
	localparam int FRAC_BITS      = 12;

	localparam int MAG_W   = COMPONENT_BITS;     // |component| up to 2^(N-1)
	localparam int ACC_W   = COMPONENT_BITS + 1; // uc + m, in [0, 2m]
	localparam int COORD_W = FRAC_BITS + 1;      // [0, 1] with FRAC_BITS fraction bits

	localparam logic [COORD_W-1:0] COORD_HALF = COORD_W'(1) << (FRAC_BITS - 1);

	// Face codes
	localparam logic [2:0] FACE_POS_X = 3'd0;
	localparam logic [2:0] FACE_NEG_X = 3'd1;
	localparam logic [2:0] FACE_POS_Y = 3'd2;
	localparam logic [2:0] FACE_NEG_Y = 3'd3;
	localparam logic [2:0] FACE_POS_Z = 3'd4;
	localparam logic [2:0] FACE_NEG_Z = 3'd5;

	typedef struct packed {
		logic signed [COMPONENT_BITS-1:0] dir_x;
		logic signed [COMPONENT_BITS-1:0] dir_y;
		logic signed [COMPONENT_BITS-1:0] dir_z;
	} cmfs_in_t;

	typedef struct packed {
		logic [2:0]         face;
		logic [COORD_W-1:0] coord_u;
		logic [COORD_W-1:0] coord_v;
		logic               zero_vector;
	} cmfs_out_t;

endpackage

[design/cube_map_face_select_unit.sv]
// Cube-map face select: takes a signed direction (dir_x, dir_y, dir_z) and returns the
// face it points at (0 +X, 1 -X, 2 +Y, 3 -Y, 4 +Z, 5 -Z) plus face coordinates u, v in
// [0, 1] with FRAC_BITS fraction bits, truncated. Largest magnitude picks the axis, ties go
// Z over Y over X, and a zero component counts as negative. An all-zero vector gives face
// -Z, u = v = 0.5 and zero_vector set. The unit takes one item every clock: busy is
// always low and results cannot be held off. Each result shows up on res with a one-cycle
// done strobe once it has passed the capture, axis-select and dividend stages and the two
// divisions, each a restoring divider unrolled one quotient bit per pipeline stage.
module cube_map_face_select_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cmfs_pkg::cmfs_in_t  dir,
	output logic                done,
	output cmfs_pkg::cmfs_out_t res
);
	import cmfs_pkg::*;

	// One compare-subtract of the divider. dbl: compare against 2m (first step),
	// shl: double the partial remainder first (fraction bits).
	function automatic logic [ACC_W:0] div_step(
		input logic [ACC_W-1:0] r,
		input logic [MAG_W-1:0] m,
		input logic             dbl,
		input logic             shl
	);
		logic [ACC_W-1:0] t;
		logic [ACC_W-1:0] d;
		t = shl ? {r[ACC_W-2:0], 1'b0} : r;
		d = dbl ? {m, 1'b0} : {1'b0, m};
		if (t >= d) begin
			return {1'b1, t - d};
		end else begin
			return {1'b0, t};
		end
	endfunction

	// No back-pressure anywhere: the pipe moves every cycle.
	assign busy = 1'b0;

	// ---------------- Stage 1: capture components and magnitudes ----------------
	logic                      vld_s1;
	logic signed [MAG_W-1:0]   x_s1, y_s1, z_s1;
	logic        [MAG_W-1:0]   ax_s1, ay_s1, az_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	// Most negative value negates to itself, which reads correctly as unsigned 2^(N-1).
	always_ff @(posedge clk) begin
		x_s1  <= dir.dir_x;
		y_s1  <= dir.dir_y;
		z_s1  <= dir.dir_z;
		ax_s1 <= dir.dir_x[MAG_W-1] ? MAG_W'(-dir.dir_x) : MAG_W'(dir.dir_x);
		ay_s1 <= dir.dir_y[MAG_W-1] ? MAG_W'(-dir.dir_y) : MAG_W'(dir.dir_y);
		az_s1 <= dir.dir_z[MAG_W-1] ? MAG_W'(-dir.dir_z) : MAG_W'(dir.dir_z);
	end

	// ---------------- Stage 2: pick the major axis and in-face components -------
	logic                      vld_s2;
	logic        [2:0]         face_s2;
	logic        [MAG_W-1:0]   m_s2;
	logic signed [ACC_W-1:0]   uc_s2, vc_s2;
	logic                      zero_s2;

	logic signed [ACC_W-1:0]   xe, ye, ze;
	logic                      z_major, y_major;
	logic        [2:0]         face_c;
	logic        [MAG_W-1:0]   m_c;
	logic signed [ACC_W-1:0]   uc_c, vc_c;

	always_comb begin
		xe      = ACC_W'(x_s1);
		ye      = ACC_W'(y_s1);
		ze      = ACC_W'(z_s1);
		z_major = (az_s1 >= ax_s1) && (az_s1 >= ay_s1);
		y_major = (ay_s1 >= ax_s1) && (ay_s1 >= az_s1);
		if (z_major) begin
			m_c  = az_s1;
			vc_c = ye;
			if (z_s1 > 0) begin
				face_c = FACE_POS_Z;
				uc_c   = xe;
			end else begin
				face_c = FACE_NEG_Z;
				uc_c   = -xe;
			end
		end else if (y_major) begin
			m_c  = ay_s1;
			uc_c = xe;
			if (y_s1 > 0) begin
				face_c = FACE_POS_Y;
				vc_c   = -ze;
			end else begin
				face_c = FACE_NEG_Y;
				vc_c   = ze;
			end
		end else begin
			m_c  = ax_s1;
			vc_c = ye;
			if (x_s1 > 0) begin
				face_c = FACE_POS_X;
				uc_c   = -ze;
			end else begin
				face_c = FACE_NEG_X;
				uc_c   = ze;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		face_s2 <= face_c;
		m_s2    <= m_c;
		uc_s2   <= uc_c;
		vc_s2   <= vc_c;
		zero_s2 <= (ax_s1 == '0) && (ay_s1 == '0) && (az_s1 == '0);
	end

	// ---------------- Stage 3: dividends uc + m and vc + m, both in [0, 2m] ------
	logic                      vld_s3;
	logic        [2:0]         face_s3;
	logic        [MAG_W-1:0]   m_s3;
	logic        [ACC_W-1:0]   au_s3, av_s3;
	logic                      zero_s3;

	logic signed [ACC_W:0]     su, sv;

	always_comb begin
		su = (ACC_W+1)'(uc_s2) + $signed({2'b00, m_s2});
		sv = (ACC_W+1)'(vc_s2) + $signed({2'b00, m_s2});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		face_s3 <= face_s2;
		m_s3    <= m_s2;
		au_s3   <= su[ACC_W-1:0];
		av_s3   <= sv[ACC_W-1:0];
		zero_s3 <= zero_s2;
	end

	// ---------------- Stages 4 .. 4+FRAC_BITS: u, v = floor(a * 2^(F-1) / m) ---
	// Step 0 yields the 2^F bit (a == 2m), step 1 the 2^(F-1) bit, then one
	// fraction bit per step. Index k of the _sd arrays is pipeline stage 4+k.
	logic               vld_sd  [0:FRAC_BITS];
	logic [2:0]         face_sd [0:FRAC_BITS];
	logic [MAG_W-1:0]   m_sd    [0:FRAC_BITS];
	logic               zero_sd [0:FRAC_BITS];
	logic [ACC_W-1:0]   ru_sd   [0:FRAC_BITS];
	logic [ACC_W-1:0]   rv_sd   [0:FRAC_BITS];
	logic [COORD_W-1:0] qu_sd   [0:FRAC_BITS];
	logic [COORD_W-1:0] qv_sd   [0:FRAC_BITS];

	for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_div
		logic               vld_in;
		logic [2:0]         face_in;
		logic [MAG_W-1:0]   m_in;
		logic               zero_in;
		logic [ACC_W-1:0]   ru_in, rv_in;
		logic [COORD_W-1:0] qu_in, qv_in;
		logic [ACC_W:0]     stp_u, stp_v;

		if (k == 0) begin : g_head
			assign vld_in  = vld_s3;
			assign face_in = face_s3;
			assign m_in    = m_s3;
			assign zero_in = zero_s3;
			assign ru_in   = au_s3;
			assign rv_in   = av_s3;
			assign qu_in   = '0;
			assign qv_in   = '0;
		end else begin : g_body
			assign vld_in  = vld_sd[k-1];
			assign face_in = face_sd[k-1];
			assign m_in    = m_sd[k-1];
			assign zero_in = zero_sd[k-1];
			assign ru_in   = ru_sd[k-1];
			assign rv_in   = rv_sd[k-1];
			assign qu_in   = qu_sd[k-1];
			assign qv_in   = qv_sd[k-1];
		end

		assign stp_u = div_step(ru_in, m_in, k == 0, k >= 2);
		assign stp_v = div_step(rv_in, m_in, k == 0, k >= 2);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k] <= 1'b0;
			end else begin
				vld_sd[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			face_sd[k] <= face_in;
			m_sd[k]    <= m_in;
			zero_sd[k] <= zero_in;
			ru_sd[k]   <= stp_u[ACC_W-1:0];
			rv_sd[k]   <= stp_v[ACC_W-1:0];
			qu_sd[k]   <= {qu_in[COORD_W-2:0], stp_u[ACC_W]};
			qv_sd[k]   <= {qv_in[COORD_W-2:0], stp_v[ACC_W]};
		end
	end

	// ---------------- Result ----------------------------------------------------
	// Zero vector: m is 0 and the quotient is meaningless, so force u = v = 0.5.
	// The face is already -Z from the tie rule.
	assign done            = vld_sd[FRAC_BITS];
	assign res.face        = face_sd[FRAC_BITS];
	assign res.coord_u     = zero_sd[FRAC_BITS] ? COORD_HALF : qu_sd[FRAC_BITS];
	assign res.coord_v     = zero_sd[FRAC_BITS] ? COORD_HALF : qv_sd[FRAC_BITS];
	assign res.zero_vector = zero_sd[FRAC_BITS];

endmodule

[tb/sv/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cmfs_pkg::*;

	// Pipeline depth of the unit: the front stages plus the divider stages.
	localparam int PIPE_DEPTH  = 3 + FRAC_BITS + 1;
	// Slowest legal run is under 600 items, each behind the longest idle burst, plus drain.
	// Take that several times over.
	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_ITEMS  = 550;
	// The last stretch of the run is driven back to back.
	localparam int CALM_TAIL   = 100;

	// One row of the directed table. Rows with known_res set carry a result
	// read straight off the spec; the others go through face_lookup.
	typedef struct {
		cmfs_in_t  dir;
		bit        known_res;
		cmfs_out_t res;
	} steer_row_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	cmfs_in_t  dir    = '0;
	logic      busy;
	logic      done;
	cmfs_out_t res;

	cmfs_out_t  pending_faces[$];   // expected results, oldest first
	steer_row_t steer_rows[$];
	int         mismatches  = 0;
	int         cycle_count = 0;

	cube_map_face_select_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.dir    (dir),
		.done   (done),
		.res    (res)
	);

	always begin
		clk = 1'b0;
		#5ns;
		clk = 1'b1;
		#5ns;
	end

	// Watchdog: a hung pipeline or lost strobe ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Face and u/v for one direction. Largest magnitude picks the axis,
	// ties go Z over Y over X, zero counts as the negative side.
	function automatic cmfs_out_t face_lookup(cmfs_in_t d);
		longint    x, y, z, ax, ay, az, m, uc, vc;
		cmfs_out_t r;
		x  = longint'(d.dir_x);
		y  = longint'(d.dir_y);
		z  = longint'(d.dir_z);
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		r  = '0;
		if (ax == 0 && ay == 0 && az == 0) begin
			// degenerate direction: center of -Z, flagged
			r.face        = FACE_NEG_Z;
			r.coord_u     = COORD_HALF;
			r.coord_v     = COORD_HALF;
			r.zero_vector = 1'b1;
			return r;
		end
		if (az >= ax && az >= ay) begin
			m  = az;
			vc = y;
			if (z > 0) begin
				r.face = FACE_POS_Z;
				uc     = x;
			end else begin
				r.face = FACE_NEG_Z;
				uc     = -x;
			end
		end else if (ay >= ax && ay >= az) begin
			m  = ay;
			uc = x;
			if (y > 0) begin
				r.face = FACE_POS_Y;
				vc     = -z;
			end else begin
				r.face = FACE_NEG_Y;
				vc     = z;
			end
		end else begin
			m  = ax;
			vc = y;
			if (x > 0) begin
				r.face = FACE_POS_X;
				uc     = -z;
			end else begin
				r.face = FACE_NEG_X;
				uc     = z;
			end
		end
		// (c + m) / 2m scaled by 2^FRAC_BITS, truncated; max 2^28 fits easily
		r.coord_u = COORD_W'(((uc + m) << FRAC_BITS) / (2 * m));
		r.coord_v = COORD_W'(((vc + m) << FRAC_BITS) / (2 * m));
		return r;
	endfunction

	function automatic cmfs_in_t make_dir(int x, int y, int z);
		cmfs_in_t d;
		d.dir_x = COMPONENT_BITS'(x);
		d.dir_y = COMPONENT_BITS'(y);
		d.dir_z = COMPONENT_BITS'(z);
		return d;
	endfunction

	task automatic add_row(int x, int y, int z, bit known, logic [2:0] f,
		int u, int v, bit zv);
		steer_row_t row;
		row.dir             = make_dir(x, y, z);
		row.known_res       = known;
		row.res.face        = f;
		row.res.coord_u     = COORD_W'(u);
		row.res.coord_v     = COORD_W'(v);
		row.res.zero_vector = zv;
		steer_rows.push_back(row);
	endtask

	// Pick one component value from a few interesting corners.
	function automatic int corner_value();
		case ($urandom_range(0, 5))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			default: return 32767;
		endcase
	endfunction

	// Random direction. Full-range values dominate; the rest aim at ties,
	// zeros, the most negative code and one-axis-dominant vectors.
	function automatic cmfs_in_t random_dir();
		int x, y, z, mag;
		x = int'($signed(16'($urandom)));
		y = int'($signed(16'($urandom)));
		z = int'($signed(16'($urandom)));
		case ($urandom_range(0, 9))
			5: begin
				// tiny values: lots of ties, zeros, the odd all-zero vector
				x = int'($urandom_range(0, 8)) - 4;
				y = int'($urandom_range(0, 8)) - 4;
				z = int'($urandom_range(0, 8)) - 4;
			end
			6: begin
				// equal magnitudes with random signs, random subset of axes
				mag = int'($urandom_range(1, 32768));
				x = $urandom_range(0, 1) ? -mag : ((mag == 32768) ? 32767 : mag);
				y = $urandom_range(0, 1) ? -mag : ((mag == 32768) ? 32767 : mag);
				z = $urandom_range(0, 1) ? -mag : ((mag == 32768) ? 32767 : mag);
				if ($urandom_range(0, 2) == 0) x = int'($signed(16'($urandom)));
				if ($urandom_range(0, 2) == 0) y = int'($signed(16'($urandom)));
			end
			7: begin
				x = corner_value();
				y = corner_value();
				z = corner_value();
			end
			8: begin
				// one large axis, the other two much smaller
				mag = int'($urandom_range(0, 2047)) - 1024;
				case ($urandom_range(0, 2))
					0: begin y = mag; z = -mag / 3; end
					1: begin x = mag; z = mag / 2; end
					default: begin x = -mag; y = mag / 5; end
				endcase
			end
			9: begin
				// knock out components
				if ($urandom_range(0, 1)) x = 0;
				if ($urandom_range(0, 1)) y = 0;
				if ($urandom_range(0, 1)) z = 0;
			end
			default: ;
		endcase
		return make_dir(x, y, z);
	endfunction

	// Hand one item to the unit: raise start and wait for the edge that
	// takes it (start high, busy low). The expected result is queued there.
	task automatic send_dir(cmfs_in_t d, cmfs_out_t want);
		start <= 1'b1;
		dir   <= d;
		do
			@(posedge clk);
		while (busy);
		pending_faces.push_back(want);
	endtask

	// Drop start for a random burst, scribbling junk on dir meanwhile.
	task automatic idle_burst();
		int n;
		n = $urandom_range(1, 18);
		start <= 1'b0;
		repeat (n) begin
			dir <= cmfs_in_t'({$urandom, $urandom});
			@(posedge clk);
		end
	endtask

	// Result checker. The strobe and payload sampled at the edge are what the
	// unit showed during the cycle just ending.
	always @(posedge clk) begin
		cmfs_out_t want;
		if (arst_n && done) begin
			if (pending_faces.size() == 0) begin
				$error("result with nothing outstanding: face %0d u %0d v %0d zero %0b",
					res.face, res.coord_u, res.coord_v, res.zero_vector);
				mismatches++;
			end else begin
				want = pending_faces.pop_front();
				if (res.face !== want.face) begin
					$error("face: expected %0d, got %0d", want.face, res.face);
					mismatches++;
				end
				if (res.coord_u !== want.coord_u) begin
					$error("coord_u: expected %0d, got %0d", want.coord_u, res.coord_u);
					mismatches++;
				end
				if (res.coord_v !== want.coord_v) begin
					$error("coord_v: expected %0d, got %0d", want.coord_v, res.coord_v);
					mismatches++;
				end
				if (res.zero_vector !== want.zero_vector) begin
					$error("zero_vector: expected %0b, got %0b",
						want.zero_vector, res.zero_vector);
					mismatches++;
				end
			end
		end
	end

	initial begin
		cmfs_in_t d;
		bit       gappy;

		// Directed table. Known results: 2048 is the face center, 4096 the
		// far edge, 0 the near edge.
		// degenerate all-zero direction
		add_row(0, 0, 0, 1, FACE_NEG_Z, 2048, 2048, 1);
		// each face along its axis, largest and most negative codes
		add_row(32767, 0, 0, 1, FACE_POS_X, 2048, 2048, 0);
		add_row(-32768, 0, 0, 1, FACE_NEG_X, 2048, 2048, 0);
		add_row(0, 32767, 0, 1, FACE_POS_Y, 2048, 2048, 0);
		add_row(0, -32768, 0, 1, FACE_NEG_Y, 2048, 2048, 0);
		add_row(0, 0, 32767, 1, FACE_POS_Z, 2048, 2048, 0);
		add_row(0, 0, -32768, 1, FACE_NEG_Z, 2048, 2048, 0);
		// smallest nonzero magnitudes
		add_row(1, 0, 0, 1, FACE_POS_X, 2048, 2048, 0);
		add_row(-1, 0, 0, 1, FACE_NEG_X, 2048, 2048, 0);
		// full three-way ties at the extremes: Z wins, corners of the face
		add_row(32767, 32767, 32767, 1, FACE_POS_Z, 4096, 4096, 0);
		add_row(-32768, -32768, -32768, 1, FACE_NEG_Z, 4096, 0, 0);
		add_row(-32767, -32767, -32767, 1, FACE_NEG_Z, 4096, 0, 0);
		// two-way ties
		add_row(5, 5, 0, 1, FACE_POS_Y, 4096, 2048, 0);
		add_row(-5, 5, 0, 1, FACE_POS_Y, 0, 2048, 0);
		add_row(-1, -1, 0, 1, FACE_NEG_Y, 0, 2048, 0);
		add_row(7, 0, -7, 1, FACE_NEG_Z, 0, 2048, 0);
		add_row(0, -9, 9, 1, FACE_POS_Z, 2048, 0, 0);
		// general cases, predicted
		add_row(3, 2, 1, 0, '0, 0, 0, 0);
		add_row(32767, -32768, 100, 0, '0, 0, 0, 0);
		add_row(-32768, 32767, -32767, 0, '0, 0, 0, 0);
		add_row(12345, -3000, 7000, 0, '0, 0, 0, 0);
		add_row(-20000, 15000, -19999, 0, '0, 0, 0, 0);
		add_row(100, -200, 300, 0, '0, 0, 0, 0);
		// alternating bit patterns
		add_row(21845, -21846, 0, 0, '0, 0, 0, 0);
		add_row(-21846, 21845, -21846, 0, '0, 0, 0, 0);

		// single reset at the start
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steer_rows[i]) begin
			if ($urandom_range(0, 2) == 0) idle_burst();
			send_dir(steer_rows[i].dir, steer_rows[i].known_res ?
				steer_rows[i].res : face_lookup(steer_rows[i].dir));
		end

		// Random part. Idle density is redrawn every 32 items so there are long
		// back-to-back runs too; the tail is always back to back.
		gappy = 1'b1;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 32 == 0) gappy = $urandom_range(0, 1);
			if (gappy && n < RAND_ITEMS - CALM_TAIL && $urandom_range(0, 2) == 0)
				idle_burst();
			d = random_dir();
			send_dir(d, face_lookup(d));
		end
		start <= 1'b0;

		// drain, then watch a while longer for stray strobes
		while (pending_faces.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
